### hw/rtl/lcb_pkg.sv
// ----------------------------------------------------------------------------
// lcb_pkg
// Shared types and constants of the latched condition bit bank.
// ----------------------------------------------------------------------------
package lcb_pkg;

    // Field widths of the stream items.
    localparam int OP_W       = 3;
    localparam int CH_W       = 2;
    localparam int IDX_W      = 8;
    localparam int FRM_W      = 16;
    localparam int TIME_W     = 32;
    localparam int OUT_IDX_W  = 2;
    localparam int OUT_BITS_W = 64;

    localparam int IN_USER_W  = OP_W + CH_W;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 72;

    // Operation codes on the input stream.
    localparam logic [OP_W-1:0] OP_SET_BIT   = 3'd0;
    localparam logic [OP_W-1:0] OP_LATCH_FRM = 3'd1;
    localparam logic [OP_W-1:0] OP_LATCH_TIM = 3'd2;
    localparam logic [OP_W-1:0] OP_FRM_TICK  = 3'd3;
    localparam logic [OP_W-1:0] OP_TIM_TICK  = 3'd4;
    localparam logic [OP_W-1:0] OP_COMPOSE   = 3'd5;

    // Channel codes of the set operation.
    localparam logic [CH_W-1:0] CH_DERIVED  = 2'd0;
    localparam logic [CH_W-1:0] CH_BASE     = 2'd1;
    localparam logic [CH_W-1:0] CH_OVERRIDE = 2'd2;

    // Command queue between the front and back parts.
    localparam int CMD_FIFO_DEPTH = 4;
    localparam int CMD_FIFO_PTR_W = 2;

    typedef enum logic [2:0] {
        CMD_SET,
        CMD_LATCH_FRM,
        CMD_LATCH_TIM,
        CMD_FRM_TICK,
        CMD_TIM_TICK,
        CMD_COMPOSE
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [CH_W-1:0]    channel;
        logic [IDX_W-1:0]   idx;
        logic               bit_value;
        logic [FRM_W-1:0]   frames;
        logic [TIME_W-1:0]  amount;
    } t_cmd;

endpackage

### hw/rtl/lcb_front.sv
// ----------------------------------------------------------------------------
// lcb_front
// Accepts input items, drops those that change nothing and turns the rest
// into commands for the back part.
// ----------------------------------------------------------------------------
module lcb_front #(
    parameter int NUM_CONDS = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [lcb_pkg::OP_W-1:0]    i_operation,
    input  logic [lcb_pkg::CH_W-1:0]    i_channel,
    input  logic [lcb_pkg::IDX_W-1:0]   i_cond_index,
    input  logic                        i_bit_value,
    input  logic [lcb_pkg::FRM_W-1:0]   i_frames,
    input  logic [lcb_pkg::TIME_W-1:0]  i_time_amount,
    output logic                        o_cmd_valid,
    output lcb_pkg::t_cmd               o_cmd,
    input  logic                        i_cmd_ready
);
    import lcb_pkg::*;

    logic  r_valid;
    t_cmd  r_cmd;
    logic  keep;
    logic  in_range;
    t_cmd  cmd;

    always_comb begin
        in_range      = 32'(i_cond_index) < NUM_CONDS;
        cmd.kind      = CMD_SET;
        cmd.channel   = i_channel;
        cmd.idx       = i_cond_index;
        cmd.bit_value = i_bit_value;
        cmd.frames    = i_frames;
        cmd.amount    = i_time_amount;
        keep          = 1'b0;
        case (i_operation)
            OP_SET_BIT: begin
                cmd.kind = CMD_SET;
                keep     = in_range && (i_channel inside {CH_DERIVED, CH_BASE, CH_OVERRIDE});
            end
            OP_LATCH_FRM: begin
                cmd.kind = CMD_LATCH_FRM;
                keep     = in_range && (i_frames != '0);
            end
            OP_LATCH_TIM: begin
                cmd.kind = CMD_LATCH_TIM;
                keep     = in_range && (i_time_amount != '0);
            end
            OP_FRM_TICK: begin
                cmd.kind = CMD_FRM_TICK;
                keep     = 1'b1;
            end
            OP_TIM_TICK: begin
                cmd.kind = CMD_TIM_TICK;
                keep     = 1'b1;
            end
            OP_COMPOSE: begin
                cmd.kind = CMD_COMPOSE;
                keep     = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_ready     = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            // Items that cause no change are taken and dropped here.
            r_valid <= i_valid && keep;
            if (i_valid && keep) begin
                r_cmd <= cmd;
            end
        end
    end

endmodule

### hw/rtl/lcb_cmd_fifo.sv
// ----------------------------------------------------------------------------
// lcb_cmd_fifo
// Short command queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module lcb_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  lcb_pkg::t_cmd  i_push_cmd,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output lcb_pkg::t_cmd  o_pop_cmd,
    input  logic           i_pop_ready
);
    import lcb_pkg::*;

    t_cmd                    r_mem [CMD_FIFO_DEPTH];
    logic [CMD_FIFO_PTR_W-1:0] r_wr_ptr;
    logic [CMD_FIFO_PTR_W-1:0] r_rd_ptr;
    logic [CMD_FIFO_PTR_W:0]   r_count;
    logic                    push;
    logic                    pop;

    assign o_push_ready = r_count != (CMD_FIFO_PTR_W+1)'(CMD_FIFO_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop_ready && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/lcb_back.sv
// ----------------------------------------------------------------------------
// lcb_back
// Executes commands: bit writes, latches, countdown scans and compose runs.
// ----------------------------------------------------------------------------
module lcb_back #(
    parameter int NUM_CONDS = 256,
    parameter int WORD_BITS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cmd_valid,
    input  lcb_pkg::t_cmd                    i_cmd,
    output logic                             o_cmd_ready,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [lcb_pkg::OUT_IDX_W-1:0]    o_out_idx,
    output logic [lcb_pkg::OUT_BITS_W-1:0]   o_out_bits,
    output logic                             o_out_last
);
    import lcb_pkg::*;

    localparam int NUM_WORDS = (NUM_CONDS + WORD_BITS - 1) / WORD_BITS;
    localparam int NB        = NUM_WORDS * WORD_BITS;
    localparam int AW        = $clog2(NUM_CONDS);
    localparam int BW        = $clog2(NB);
    localparam int WI        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LATCH,
        S_SCAN,
        S_COMPOSE
    } t_state;

    t_state               r_state;
    t_cmd                 r_cmd;
    logic [NB-1:0]        r_derived;
    logic [NB-1:0]        r_base;
    logic [NB-1:0]        r_override;
    logic [NB-1:0]        r_latched;
    logic                 r_frm_run [NUM_CONDS];
    logic                 r_tim_run [NUM_CONDS];
    logic [FRM_W-1:0]     mem_frm [NUM_CONDS];
    logic [TIME_W-1:0]    mem_tim [NUM_CONDS];
    logic [FRM_W-1:0]     r_frm_rd;
    logic [TIME_W-1:0]    r_tim_rd;
    logic [AW:0]          r_rd_cnt;
    logic [AW-1:0]        r_wr_addr;
    logic                 r_wr_valid;
    logic [WI-1:0]        r_word;
    logic                 r_out_valid;
    logic [OUT_IDX_W-1:0] r_out_idx;
    logic [OUT_BITS_W-1:0] r_out_bits;
    logic                 r_out_last;

    logic                 pop;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        rmw_addr;
    logic                 frun;
    logic                 trun;
    logic                 frm_we;
    logic [FRM_W-1:0]     frm_wd;
    logic                 tim_we;
    logic [TIME_W-1:0]    tim_wd;
    logic                 scan_clr;
    logic                 scan_done;
    logic                 out_free;
    logic [NB-1:0]        composite;
    logic [WORD_BITS-1:0] word_sel;
    logic                 word_last;

    assign o_cmd_ready = r_state == S_IDLE;
    assign pop         = (r_state == S_IDLE) && i_cmd_valid;
    assign scan_done   = r_rd_cnt == (AW+1)'(NUM_CONDS);
    assign out_free    = !r_out_valid || i_out_ready;
    assign composite   = r_derived | r_base | r_latched | r_override;
    assign word_sel    = composite[r_word*WORD_BITS +: WORD_BITS];
    assign word_last   = r_word == WI'(NUM_WORDS - 1);

    always_comb begin
        rd_addr  = (r_state == S_SCAN) ? r_rd_cnt[AW-1:0] : AW'(i_cmd.idx);
        rmw_addr = (r_state == S_SCAN) ? r_wr_addr : AW'(r_cmd.idx);
        frun     = r_frm_run[rmw_addr];
        trun     = r_tim_run[rmw_addr];
        frm_we   = 1'b0;
        tim_we   = 1'b0;
        frm_wd   = r_cmd.frames;
        tim_wd   = r_cmd.amount;
        scan_clr = 1'b0;
        if (r_state == S_LATCH) begin
            // A running countdown keeps the larger of the two durations.
            if (r_cmd.kind == CMD_LATCH_FRM) begin
                frm_we = !frun || (r_frm_rd < r_cmd.frames);
            end else begin
                tim_we = !trun || (r_tim_rd < r_cmd.amount);
            end
        end else if (r_state == S_SCAN && r_wr_valid) begin
            if (r_cmd.kind == CMD_FRM_TICK) begin
                scan_clr = frun && (r_frm_rd == '0);
                frm_we   = frun && (r_frm_rd != '0);
                frm_wd   = r_frm_rd - 1'b1;
            end else begin
                scan_clr = trun && (r_tim_rd <= r_cmd.amount);
                tim_we   = trun && (r_tim_rd > r_cmd.amount);
                tim_wd   = r_tim_rd - r_cmd.amount;
            end
        end
    end

    // Countdown memories: one read and one write port each.
    always_ff @(posedge i_clk) begin
        if (frm_we) begin
            mem_frm[rmw_addr] <= frm_wd;
        end
        if (tim_we) begin
            mem_tim[rmw_addr] <= tim_wd;
        end
        r_frm_rd <= mem_frm[rd_addr];
        r_tim_rd <= mem_tim[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_derived   <= '0;
            r_base      <= '0;
            r_override  <= '0;
            r_latched   <= '0;
            r_out_valid <= 1'b0;
            r_wr_valid  <= 1'b0;
            r_rd_cnt    <= '0;
            r_word      <= '0;
            for (int i = 0; i < NUM_CONDS; i++) begin
                r_frm_run[i] <= 1'b0;
                r_tim_run[i] <= 1'b0;
            end
        end else begin
            // During a compose run the output register is reloaded below.
            if (r_out_valid && i_out_ready && r_state != S_COMPOSE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        r_cmd <= i_cmd;
                        case (i_cmd.kind)
                            CMD_SET: begin
                                case (i_cmd.channel)
                                    CH_DERIVED:  r_derived[BW'(i_cmd.idx)]  <= i_cmd.bit_value;
                                    CH_BASE:     r_base[BW'(i_cmd.idx)]     <= i_cmd.bit_value;
                                    CH_OVERRIDE: r_override[BW'(i_cmd.idx)] <= i_cmd.bit_value;
                                    default: begin
                                    end
                                endcase
                            end
                            CMD_LATCH_FRM, CMD_LATCH_TIM: begin
                                r_state <= S_LATCH;
                            end
                            CMD_FRM_TICK, CMD_TIM_TICK: begin
                                r_state    <= S_SCAN;
                                r_rd_cnt   <= '0;
                                r_wr_valid <= 1'b0;
                            end
                            CMD_COMPOSE: begin
                                r_state <= S_COMPOSE;
                                r_word  <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_LATCH: begin
                    r_latched[BW'(r_cmd.idx)] <= 1'b1;
                    if (r_cmd.kind == CMD_LATCH_FRM) begin
                        r_frm_run[rmw_addr] <= 1'b1;
                    end else begin
                        r_tim_run[rmw_addr] <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_SCAN: begin
                    // Read of entry n overlaps the update of entry n-1.
                    if (scan_clr) begin
                        r_latched[BW'(r_wr_addr)] <= 1'b0;
                        if (r_cmd.kind == CMD_FRM_TICK) begin
                            r_frm_run[r_wr_addr] <= 1'b0;
                        end else begin
                            r_tim_run[r_wr_addr] <= 1'b0;
                        end
                    end
                    if (scan_done) begin
                        r_wr_valid <= 1'b0;
                        r_state    <= S_IDLE;
                    end else begin
                        r_wr_addr  <= r_rd_cnt[AW-1:0];
                        r_wr_valid <= 1'b1;
                        r_rd_cnt   <= r_rd_cnt + 1'b1;
                    end
                end
                S_COMPOSE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_idx   <= OUT_IDX_W'(r_word);
                        r_out_bits  <= OUT_BITS_W'(word_sel);
                        r_out_last  <= word_last;
                        if (word_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_word <= r_word + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_idx   = r_out_idx;
    assign o_out_bits  = r_out_bits;
    assign o_out_last  = r_out_last;

endmodule

### hw/rtl/latched_condition_bit_bank.sv
// ----------------------------------------------------------------------------
// latched_condition_bit_bank
// Condition bit bank with derived, base, latched and override channels.
// ----------------------------------------------------------------------------
// Items enter on the s_axis channel: tuser carries the operation and the
// channel, tdata the condition index, bit value, frame count and 16.16 time.
// Items that change nothing are taken and dropped at the front. Others pass
// a register stage and a four-entry command queue to the execution engine.
// A set is done as the engine takes the command; a latch reads, then writes
// the countdown memory. A frame or time tick scans every condition through the
// countdown memory's single read port. A compose run puts one word per cycle
// on m_axis while m_axis is not stalled, NUM_WORDS items with tlast on the
// final one; word_index is the low two bits of the word number. With an empty
// queue a compose item passes the front register, the command queue and the
// compose state before its first word is loaded into the output register.
// A stall on m_axis holds the output register and pauses the compose run; the
// front keeps taking items until the command queue and its own register are full.
// Reset clears all channel bits and stops every countdown; the countdown
// memories need no clearing because the value of a stopped entry is unused.
// ----------------------------------------------------------------------------
module latched_condition_bit_bank #(
    parameter int NUM_CONDS = 256,
    parameter int WORD_BITS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // cond_index[7:0], bit_value[8], frames[24:9], time_amount[56:25], zero pad
    input  logic [lcb_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // operation[2:0], channel[4:3]
    input  logic [lcb_pkg::IN_USER_W-1:0]      i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // word_index[1:0], word_bits[65:2], zero pad
    output logic [lcb_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    output logic                               o_m_axis_tlast
);
    import lcb_pkg::*;

    logic                  front_valid;
    t_cmd                  front_cmd;
    logic                  fifo_push_ready;
    logic                  fifo_pop_valid;
    t_cmd                  fifo_pop_cmd;
    logic                  back_ready;
    logic [OUT_IDX_W-1:0]  out_idx;
    logic [OUT_BITS_W-1:0] out_bits;

    lcb_front #(
        .NUM_CONDS (NUM_CONDS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_operation   (i_s_axis_tuser[OP_W-1:0]),
        .i_channel     (i_s_axis_tuser[OP_W +: CH_W]),
        .i_cond_index  (i_s_axis_tdata[IDX_W-1:0]),
        .i_bit_value   (i_s_axis_tdata[IDX_W]),
        .i_frames      (i_s_axis_tdata[IDX_W+1 +: FRM_W]),
        .i_time_amount (i_s_axis_tdata[IDX_W+1+FRM_W +: TIME_W]),
        .o_cmd_valid   (front_valid),
        .o_cmd         (front_cmd),
        .i_cmd_ready   (fifo_push_ready)
    );

    lcb_cmd_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_cmd   (front_cmd),
        .o_push_ready (fifo_push_ready),
        .o_pop_valid  (fifo_pop_valid),
        .o_pop_cmd    (fifo_pop_cmd),
        .i_pop_ready  (back_ready)
    );

    lcb_back #(
        .NUM_CONDS (NUM_CONDS),
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (fifo_pop_valid),
        .i_cmd       (fifo_pop_cmd),
        .o_cmd_ready (back_ready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_idx   (out_idx),
        .o_out_bits  (out_bits),
        .o_out_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {(OUT_DATA_W - OUT_BITS_W - OUT_IDX_W)'(0), out_bits, out_idx};

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the latched condition bit bank.
// ----------------------------------------------------------------------------
// Items are driven on the input stream at the falling clock edge. Every
// accepted item is run through a model of the four channels and the frame and
// time countdowns that the bench keeps itself. A compose item queues the four
// words it must produce, and each word taken from the output stream is
// compared with the oldest one queued. A short directed run covers the field
// extremes and the corner cases. A random run follows, mostly latches, ticks
// and composes on a small set of conditions, so that countdowns overlap and
// expire. Both stream sides idle in random bursts, and the final stretch runs
// without any idling.
// ----------------------------------------------------------------------------
module tb;
    import lcb_pkg::*;

    localparam int NUM_CONDS      = 256;
    localparam int WORD_BITS      = 64;
    localparam int NUM_WORDS      = NUM_CONDS / WORD_BITS;
    localparam int RANDOM_ITEMS   = 320;
    localparam int CALM_ITEMS     = 60;
    localparam int WATCHDOG_LIMIT = 10000;
    localparam int DRAIN_CYCLES   = NUM_CONDS + 40;

    // Codes that the block must take and ignore.
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
    localparam logic [CH_W-1:0] CH_SPARE   = 2'd3;

    typedef struct packed {
        logic [OUT_IDX_W-1:0]  index;
        logic [OUT_BITS_W-1:0] bits;
        logic                  last;
    } t_word;

    class cond_bank_tracker;
        logic [WORD_BITS-1:0] derived[NUM_WORDS];
        logic [WORD_BITS-1:0] base[NUM_WORDS];
        logic [WORD_BITS-1:0] override_w[NUM_WORDS];
        logic [WORD_BITS-1:0] latched[NUM_WORDS];
        logic [FRM_W-1:0]     frm_left[NUM_CONDS];
        bit                   frm_on[NUM_CONDS];
        logic [TIME_W-1:0]    time_left[NUM_CONDS];
        bit                   time_on[NUM_CONDS];
        t_word                due_words[$];
        int                   errors;

        function new();
            for (int w = 0; w < NUM_WORDS; w++) begin
                derived[w]    = '0;
                base[w]       = '0;
                override_w[w] = '0;
                latched[w]    = '0;
            end
            for (int i = 0; i < NUM_CONDS; i++) begin
                frm_left[i]  = '0;
                frm_on[i]    = 1'b0;
                time_left[i] = '0;
                time_on[i]   = 1'b0;
            end
            errors = 0;
        endfunction

        // Applies one accepted item to the model and queues any words it owes.
        function void note_item(logic [OP_W-1:0] op, logic [CH_W-1:0] ch,
                                logic [IDX_W-1:0] idx, logic bval,
                                logic [FRM_W-1:0] frm, logic [TIME_W-1:0] amt);
            int    w;
            int    b;
            t_word wd;
            w = int'(idx) / WORD_BITS;
            b = int'(idx) % WORD_BITS;
            case (op)
                OP_SET_BIT: begin
                    case (ch)
                        CH_DERIVED:  derived[w][b]    = bval;
                        CH_BASE:     base[w][b]       = bval;
                        CH_OVERRIDE: override_w[w][b] = bval;
                        default: ;
                    endcase
                end
                OP_LATCH_FRM: begin
                    if (frm != 0) begin
                        latched[w][b] = 1'b1;
                        if (!frm_on[idx] || frm_left[idx] < frm) frm_left[idx] = frm;
                        frm_on[idx] = 1'b1;
                    end
                end
                OP_LATCH_TIM: begin
                    if (amt != 0) begin
                        latched[w][b] = 1'b1;
                        if (!time_on[idx] || time_left[idx] < amt) time_left[idx] = amt;
                        time_on[idx] = 1'b1;
                    end
                end
                OP_FRM_TICK: begin
                    // A count already at zero expires; the rest count down.
                    for (int i = 0; i < NUM_CONDS; i++) begin
                        if (frm_on[i]) begin
                            if (frm_left[i] == 0) begin
                                latched[i / WORD_BITS][i % WORD_BITS] = 1'b0;
                                frm_on[i] = 1'b0;
                            end else begin
                                frm_left[i] = frm_left[i] - 1'b1;
                            end
                        end
                    end
                end
                OP_TIM_TICK: begin
                    for (int i = 0; i < NUM_CONDS; i++) begin
                        if (time_on[i]) begin
                            if (time_left[i] <= amt) begin
                                time_left[i] = '0;
                                latched[i / WORD_BITS][i % WORD_BITS] = 1'b0;
                                time_on[i] = 1'b0;
                            end else begin
                                time_left[i] = time_left[i] - amt;
                            end
                        end
                    end
                end
                OP_COMPOSE: begin
                    for (int i = 0; i < NUM_WORDS; i++) begin
                        wd.index = OUT_IDX_W'(i);
                        wd.bits  = derived[i] | base[i] | latched[i] | override_w[i];
                        wd.last  = (i == NUM_WORDS - 1);
                        due_words.push_back(wd);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_word(logic [OUT_IDX_W-1:0] index,
                                 logic [OUT_BITS_W-1:0] bits, logic last);
            t_word wd;
            if (due_words.size() == 0) begin
                $error("unexpected result: word_index %0d, word_bits %h, last %0d",
                       index, bits, last);
                errors++;
                return;
            end
            wd = due_words.pop_front();
            if (index !== wd.index) begin
                $error("word_index: expected %0d, actual %0d", wd.index, index);
                errors++;
            end
            if (bits !== wd.bits) begin
                $error("word_bits: expected %h, actual %h", wd.bits, bits);
                errors++;
            end
            if (last !== wd.last) begin
                $error("last: expected %0d, actual %0d", wd.last, last);
                errors++;
            end
        endfunction

        function void check_drained();
            if (due_words.size() != 0) begin
                $error("%0d result words never arrived", due_words.size());
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    // cond_index[7:0], bit_value[8], frames[24:9], time_amount[56:25], zero pad
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    // operation[2:0], channel[4:3]
    logic [IN_USER_W-1:0]  i_s_axis_tuser = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // word_index[1:0], word_bits[65:2], zero pad
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tlast;

    cond_bank_tracker bank_model = new();
    bit calm = 1'b0;
    int quiet_cycles = 0;

    latched_condition_bit_bank #(
        .NUM_CONDS(NUM_CONDS),
        .WORD_BITS(WORD_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Both handshakes are observed here, and the watchdog counts dead cycles.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                bank_model.note_item(i_s_axis_tuser[2:0], i_s_axis_tuser[4:3],
                                     i_s_axis_tdata[7:0], i_s_axis_tdata[8],
                                     i_s_axis_tdata[24:9], i_s_axis_tdata[56:25]);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                bank_model.check_word(o_m_axis_tdata[1:0], o_m_axis_tdata[65:2],
                                      o_m_axis_tlast);
            end
            if ((i_s_axis_tvalid && o_s_axis_tready) ||
                (o_m_axis_tvalid && i_m_axis_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Output side: ready in runs, with stalls between them.
    initial begin
        int run;
        @(posedge i_rst_n);
        forever begin
            if (calm) begin
                @(negedge i_clk);
                i_m_axis_tready <= 1'b1;
            end else begin
                run = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 40);
                repeat (run) begin
                    @(negedge i_clk);
                    i_m_axis_tready <= 1'b1;
                end
                if (!calm) begin
                    run = $urandom_range(1, 15);
                    repeat (run) begin
                        @(negedge i_clk);
                        i_m_axis_tready <= 1'b0;
                    end
                end
            end
        end
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                             input logic [IDX_W-1:0] idx, input logic bval,
                             input logic [FRM_W-1:0] frm,
                             input logic [TIME_W-1:0] amt);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= {ch, op};
        i_s_axis_tdata  <= {7'd0, amt, frm, bval, idx};
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic hold_off(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
        end
    endtask

    task automatic wait_for_results();
        hold_off(1);
        while (bank_model.due_words.size() != 0) @(negedge i_clk);
    endtask

    // Picks a condition from six per word half of the time, so that latches
    // on the same condition stack up.
    function automatic logic [IDX_W-1:0] pick_cond();
        if ($urandom_range(0, 1) == 0)
            return IDX_W'($urandom_range(0, 3) * WORD_BITS + $urandom_range(0, 5));
        return IDX_W'($urandom);
    endfunction

    task automatic send_random_item(output bit counted);
        logic [OP_W-1:0]   op;
        logic [CH_W-1:0]   ch;
        logic [IDX_W-1:0]  idx;
        logic              bval;
        logic [FRM_W-1:0]  frm;
        logic [TIME_W-1:0] amt;
        int                pick;
        int                sub;
        ch      = CH_W'($urandom_range(0, 3));
        idx     = pick_cond();
        bval    = 1'($urandom_range(0, 1));
        frm     = FRM_W'($urandom);
        amt     = $urandom;
        counted = 1'b1;
        pick    = $urandom_range(0, 99);
        sub     = $urandom_range(0, 99);
        if (pick < 20) begin
            op = OP_SET_BIT;
        end else if (pick < 35) begin
            op = OP_LATCH_FRM;
            if (sub < 70)      frm = FRM_W'($urandom_range(1, 5));
            else if (sub < 90) frm = FRM_W'($urandom_range(0, 300));
        end else if (pick < 50) begin
            op = OP_LATCH_TIM;
            if (sub < 5)       amt = '0;
            else if (sub < 70) amt = $urandom_range(1, 32'h0004_0000);
        end else if (pick < 65) begin
            op = OP_FRM_TICK;
        end else if (pick < 78) begin
            op = OP_TIM_TICK;
            if (sub < 60)      amt = $urandom_range(0, 32'h0002_0000);
            else if (sub < 90) amt = $urandom_range(0, 32'h0000_1000);
        end else if (pick < 96) begin
            op = OP_COMPOSE;
        end else begin
            op = ($urandom_range(0, 1) == 0) ? OP_SPARE_6 : OP_SPARE_7;
            counted = 1'b0;
        end
        send_item(op, ch, idx, bval, frm, amt);
    endtask

    initial begin
        int  sent;
        bit  counted;
        bit  gaps_on;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part.
        send_item(OP_COMPOSE, CH_DERIVED, 8'd0, 1'b0, 16'd0, 32'd0);
        send_item(OP_SET_BIT, CH_DERIVED, 8'd0, 1'b1, 16'd0, 32'd0);
        send_item(OP_SET_BIT, CH_BASE, 8'd255, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(OP_SET_BIT, CH_OVERRIDE, 8'd64, 1'b1, 16'd0, 32'd0);
        send_item(OP_SET_BIT, CH_SPARE, 8'd5, 1'b1, 16'd0, 32'd0);
        send_item(OP_SPARE_6, CH_BASE, 8'd7, 1'b1, 16'd3, 32'd3);
        send_item(OP_SPARE_7, CH_OVERRIDE, 8'd8, 1'b1, 16'd3, 32'd3);
        // Zero durations are ignored.
        send_item(OP_LATCH_FRM, CH_DERIVED, 8'd10, 1'b0, 16'd0, 32'd5);
        send_item(OP_LATCH_TIM, CH_DERIVED, 8'd11, 1'b0, 16'd5, 32'd0);
        // A shorter latch on a running count keeps the longer one.
        send_item(OP_LATCH_FRM, CH_DERIVED, 8'd10, 1'b0, 16'd2, 32'd0);
        send_item(OP_LATCH_FRM, CH_DERIVED, 8'd10, 1'b0, 16'd1, 32'd0);
        send_item(OP_LATCH_TIM, CH_DERIVED, 8'd10, 1'b0, 16'd0, 32'h0001_8000);
        send_item(OP_LATCH_TIM, CH_DERIVED, 8'd200, 1'b0, 16'd0, 32'hFFFF_FFFF);
        send_item(OP_LATCH_FRM, CH_DERIVED, 8'd201, 1'b0, 16'hFFFF, 32'd0);
        send_item(OP_COMPOSE, CH_DERIVED, 8'd0, 1'b0, 16'd0, 32'd0);
        // A count of two frames expires on the third tick; the time count on 10 keeps going.
        send_item(OP_FRM_TICK, CH_DERIVED, 8'd0, 1'b0, 16'd0, 32'd0);
        send_item(OP_FRM_TICK, CH_DERIVED, 8'd0, 1'b0, 16'd0, 32'd0);
        send_item(OP_COMPOSE, CH_DERIVED, 8'd0, 1'b0, 16'd0, 32'd0);
        send_item(OP_FRM_TICK, CH_DERIVED, 8'd0, 1'b0, 16'd0, 32'd0);
        send_item(OP_COMPOSE, CH_DERIVED, 8'd0, 1'b0, 16'd0, 32'd0);
        // Re-latch 10 by time only, then let it expire exactly at zero.
        send_item(OP_LATCH_TIM, CH_DERIVED, 8'd10, 1'b0, 16'd0, 32'h0001_0000);
        send_item(OP_TIM_TICK, CH_DERIVED, 8'd0, 1'b0, 16'd0, 32'd0);
        send_item(OP_TIM_TICK, CH_DERIVED, 8'd0, 1'b0, 16'd0, 32'h0001_0000);
        send_item(OP_TIM_TICK, CH_DERIVED, 8'd0, 1'b0, 16'd0, 32'h0000_8000);
        send_item(OP_COMPOSE, CH_DERIVED, 8'd0, 1'b0, 16'd0, 32'd0);
        send_item(OP_TIM_TICK, CH_DERIVED, 8'd0, 1'b0, 16'd0, 32'hFFFF_FFFF);
        send_item(OP_SET_BIT, CH_DERIVED, 8'd0, 1'b0, 16'd0, 32'd0);
        send_item(OP_COMPOSE, CH_DERIVED, 8'd0, 1'b0, 16'd0, 32'd0);
        wait_for_results();

        // Random part.
        sent    = 0;
        gaps_on = 1'b1;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
            if (sent % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
            if (sent == RANDOM_ITEMS / 2) wait_for_results();
            if (!calm && gaps_on && $urandom_range(0, 4) == 0)
                hold_off($urandom_range(1, 15));
            send_random_item(counted);
            if (counted) sent++;
        end
        send_item(OP_COMPOSE, CH_DERIVED, 8'd0, 1'b0, 16'd0, 32'd0);
        hold_off(1);

        while (bank_model.due_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        bank_model.check_drained();
        if (bank_model.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
